### rtl/modbus_rtu_request_parser_defines.svh
// assertion macros for the modbus rtu request parser
// expects signals named clk and rst_n in the module that uses them
`ifndef MODBUS_RTU_REQUEST_PARSER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_PARSER_DEFINES_SVH

// checked property, disabled while reset is asserted
`define MRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also holds during reset
`define MRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mrp_pkg.sv
// shared types, codes and the crc-16 step for the modbus rtu request parser
// no dependencies
package mrp_pkg;

  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [7:0]  STATION_ID_RESET = 8'h01;

  // input operation codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // result status codes
  localparam logic [2:0] ST_PROGRESS = 3'd0;
  localparam logic [2:0] ST_FRAME_OK = 3'd1;
  localparam logic [2:0] ST_CRC_ERR  = 3'd2;
  localparam logic [2:0] ST_BUSY     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  // next field expected
  typedef enum logic [2:0] {
    PH_ID    = 3'd0,
    PH_FUNC  = 3'd1,
    PH_ADDR  = 3'd2,
    PH_COUNT = 3'd3,
    PH_CRC   = 3'd4,
    PH_HOLD  = 3'd5
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  phase;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [16:0] quantity_bytes;
    logic [15:0] received_crc;
  } out_item_t;

  // modbus crc-16 over one byte, reflected, lsb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/mrp_parser.sv
// frame parser: phase state, captured fields and running crc, one byte per cycle while push is high
// depends on mrp_pkg and the assertion macro header
`include "modbus_rtu_request_parser_defines.svh"

module mrp_parser
  import mrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic [7:0] station_id,
  input  logic      push,
  input  in_item_t  item,
  output out_item_t result
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  slave_r, slave_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [16:0] qty_r, qty_nxt;
  logic [15:0] fcrc_r, fcrc_nxt;
  logic        held_r, held_nxt;

  // captured values before a possible parser reset
  phase_t      cap_phase;
  logic [3:0]  cap_count;
  logic [15:0] cap_crc;
  logic [7:0]  cap_slave;
  logic [7:0]  cap_func;
  logic [15:0] cap_addr;
  logic [16:0] cap_qty;
  logic [15:0] cap_fcrc;
  logic        cap_held;
  logic        do_clear;
  logic [2:0]  res_status;
  logic [2:0]  res_phase;

  logic [7:0]  b;
  logic [3:0]  count_inc;
  logic [15:0] crc_step;

  assign b         = item.rx_byte;
  assign count_inc = count_r + 4'd1;
  assign crc_step  = crc16_byte(crc_r, b);

  // field capture and phase advance for one transaction
  always_comb begin
    cap_phase  = phase_r;
    cap_count  = count_r;
    cap_crc    = crc_r;
    cap_slave  = slave_r;
    cap_func   = func_r;
    cap_addr   = addr_r;
    cap_qty    = qty_r;
    cap_fcrc   = fcrc_r;
    cap_held   = held_r;
    do_clear   = 1'b0;
    res_status = ST_PROGRESS;
    res_phase  = 3'(phase_r);
    if (item.op == OP_CLEAR) begin
      do_clear   = 1'b1;
      cap_slave  = '0;
      cap_func   = '0;
      cap_addr   = '0;
      cap_qty    = '0;
      cap_fcrc   = '0;
      res_status = ST_CLEARED;
      res_phase  = 3'(PH_ID);
    end else if (held_r) begin
      res_status = ST_BUSY;
      res_phase  = 3'(PH_HOLD);
    end else begin
      case (phase_r)
        PH_ID: begin
          if (b == station_id) begin
            cap_slave = b;
            cap_crc   = crc_step;
            cap_count = count_inc;
            cap_phase = PH_FUNC;
          end
        end
        PH_FUNC: begin
          cap_func  = b;
          cap_crc   = crc_step;
          cap_count = count_inc;
          cap_phase = PH_ADDR;
        end
        PH_ADDR: begin
          cap_addr  = {addr_r[7:0], b};
          cap_crc   = crc_step;
          cap_count = count_inc;
          if (count_inc >= 4'd4) begin
            cap_phase = PH_COUNT;
          end
        end
        PH_COUNT: begin
          cap_crc   = crc_step;
          cap_count = count_inc;
          if (count_inc >= 4'd6) begin
            cap_qty   = {qty_r[7:0], b, 1'b0};
            cap_phase = PH_CRC;
          end else begin
            cap_qty = {1'b0, qty_r[7:0], b};
          end
        end
        PH_CRC: begin
          cap_fcrc  = {fcrc_r[7:0], b};
          cap_count = count_inc;
          if (count_inc >= 4'd8) begin
            // crc goes out low byte first
            if ({fcrc_r[7:0], b} == {crc_r[7:0], crc_r[15:8]}) begin
              cap_held   = 1'b1;
              cap_phase  = PH_HOLD;
              res_status = ST_FRAME_OK;
            end else begin
              do_clear   = 1'b1;
              res_status = ST_CRC_ERR;
            end
          end
        end
        default: begin
          // unreachable phase, fall back to waiting for an id
          do_clear  = 1'b1;
          cap_slave = '0;
          cap_func  = '0;
          cap_addr  = '0;
          cap_qty   = '0;
          cap_fcrc  = '0;
        end
      endcase
      if (res_status == ST_PROGRESS) begin
        res_phase = do_clear ? 3'(PH_ID) : 3'(cap_phase);
      end else if (res_status == ST_CRC_ERR) begin
        res_phase = 3'(PH_ID);
      end else begin
        res_phase = 3'(PH_HOLD);
      end
    end
  end

  // next state, parser reset on clear, crc error or an unreachable phase
  always_comb begin
    if (do_clear) begin
      phase_nxt = PH_ID;
      count_nxt = '0;
      crc_nxt   = CRC_INIT;
      slave_nxt = '0;
      func_nxt  = '0;
      addr_nxt  = '0;
      qty_nxt   = '0;
      fcrc_nxt  = '0;
      held_nxt  = 1'b0;
    end else begin
      phase_nxt = cap_phase;
      count_nxt = cap_count;
      crc_nxt   = cap_crc;
      slave_nxt = cap_slave;
      func_nxt  = cap_func;
      addr_nxt  = cap_addr;
      qty_nxt   = cap_qty;
      fcrc_nxt  = cap_fcrc;
      held_nxt  = cap_held;
    end
  end

  // result for this transaction
  always_comb begin
    result.status         = res_status;
    result.phase          = res_phase;
    result.slave_id       = cap_slave;
    result.function_code  = cap_func;
    result.start_address  = cap_addr;
    result.quantity_bytes = cap_qty;
    result.received_crc   = cap_fcrc;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID;
      count_r <= '0;
      crc_r   <= CRC_INIT;
      slave_r <= '0;
      func_r  <= '0;
      addr_r  <= '0;
      qty_r   <= '0;
      fcrc_r  <= '0;
      held_r  <= 1'b0;
    end else if (push) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      slave_r <= slave_nxt;
      func_r  <= func_nxt;
      addr_r  <= addr_nxt;
      qty_r   <= qty_nxt;
      fcrc_r  <= fcrc_nxt;
      held_r  <= held_nxt;
    end
  end

  // held frame always sits in the holding phase
  `MRP_ASSERT(a_held_phase, held_r == (phase_r == PH_HOLD), "held flag and phase disagree")
  // waiting for an id means no byte has been counted
  `MRP_ASSERT(a_id_count, (phase_r == PH_ID) |-> (count_r == 4'd0), "byte count not clear at id")
  // crc bytes only follow the six covered bytes
  `MRP_ASSERT(a_crc_count, (phase_r == PH_CRC) |-> (count_r == 4'd6 || count_r == 4'd7),
              "byte count out of step in crc phase")

endmodule

### rtl/mrp_out_buf.sv
// result register with a skid stage so input and output stall independently
// depends on mrp_pkg and the assertion macro header
`include "modbus_rtu_request_parser_defines.svh"

module mrp_out_buf
  import mrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  logic      pop;
  logic      out_free;

  assign pop      = out_valid_r & ~out_stall;
  assign out_free = pop | ~out_valid_r;
  assign full     = skid_valid_r;

  // refill the output register from the skid stage first
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        if (push) begin
          out_data_nxt = push_data;
        end
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skid entry is never occupied ahead of the output register
  `MRP_ASSERT(a_skid_order, skid_valid_r |-> out_valid_r, "skid holds data with output empty")
  // a transaction arriving behind a stalled result lands in the skid stage
  `MRP_ASSERT(a_skid_fill, (push && out_valid_r && out_stall) |=> skid_valid_r,
              "transaction lost behind stalled result")
  // the skid stage drains into the output as soon as the output moves
  `MRP_ASSERT(a_skid_drain, (skid_valid_r && !out_stall) |=> (out_valid_r && !skid_valid_r),
              "skid stage did not drain")

endmodule

### rtl/modbus_rtu_request_parser.sv
// top level of the modbus rtu request parser: station id register, parser, result buffer
// depends on mrp_pkg, mrp_parser and mrp_out_buf
//
// Usage
//   Input channel (in_valid, in_stall, in_data): one transaction per received
//   byte (op 0) or a clear (op 1). Every transaction yields exactly one result
//   on the output channel (out_valid, out_stall, out_data) in the same order.
//   A transaction accepted at a clock edge lands in out_data at that edge, or
//   in the skid stage if the output is stalled. Throughput is one transaction
//   per cycle while in_stall is low; the crc over a byte's eight bits is combinational.
//   cfg_wr_en / cfg_wr_data write the station id, taken at the clock edge;
//   write it only while no transaction is in flight.
//   Reset (rst_n low at a clock edge) sets the station id to 1, the parser to
//   waiting for an id, the crc to 0xFFFF and empties the result buffer.
//   When the receiver stalls, the current result holds and one more
//   transaction is taken into a skid stage; in_stall then rises until the
//   output moves again, so no result is dropped or repeated.
module modbus_rtu_request_parser
  import mrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  logic [7:0] station_id_r;
  logic       push;
  logic       buf_full;
  out_item_t  parse_result;

  // station id register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_id_r <= STATION_ID_RESET;
    end else if (cfg_wr_en) begin
      station_id_r <= cfg_wr_data;
    end
  end

  // input transaction accept
  assign in_stall = buf_full;
  assign push     = in_valid & ~buf_full;

  mrp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .station_id (station_id_r),
    .push       (push),
    .item       (in_data),
    .result     (parse_result)
  );

  mrp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (parse_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### test/tb_modbus_rtu_request_parser.sv
// self-checking testbench for the modbus rtu request parser: random request frames,
// crc errors, busy bytes and clears, checked against a behavioral parser model
// depends on mrp_pkg and modbus_rtu_request_parser
module tb_modbus_rtu_request_parser
  import mrp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int SHOWN_ERRORS   = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  modbus_rtu_request_parser DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // parser model: station id register and frame state
  // ---------------------------------------------------------------------------
  logic [7:0]  station_model;
  phase_t      next_field;
  logic [3:0]  bytes_seen;
  logic [15:0] crc_acc;
  logic [7:0]  cap_slave;
  logic [7:0]  cap_function;
  logic [15:0] cap_address;
  logic [16:0] cap_quantity;
  logic [15:0] cap_crc;
  logic        frame_holding;

  // reflected crc-16, one input bit per shift
  function automatic logic [15:0] crc16_modbus_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void restart_frame();
    next_field    = PH_ID;
    bytes_seen    = '0;
    crc_acc       = CRC_INIT;
    cap_slave     = '0;
    cap_function  = '0;
    cap_address   = '0;
    cap_quantity  = '0;
    cap_crc       = '0;
    frame_holding = 1'b0;
  endfunction

  function automatic out_item_t frame_report(logic [2:0] st, phase_t ph);
    out_item_t r;
    r.status         = st;
    r.phase          = ph;
    r.slave_id       = cap_slave;
    r.function_code  = cap_function;
    r.start_address  = cap_address;
    r.quantity_bytes = cap_quantity;
    r.received_crc   = cap_crc;
    return r;
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    crc_acc    = crc16_modbus_step(crc_acc, b);
    bytes_seen = bytes_seen + 4'd1;
  endfunction

  // expected result for one accepted transaction, updates the model state
  function automatic out_item_t parse_request_byte(in_item_t item);
    out_item_t   r;
    logic [7:0]  b;
    logic [15:0] wire_crc;
    b = item.rx_byte;
    if (item.op == OP_CLEAR) begin
      restart_frame();
      return frame_report(ST_CLEARED, PH_ID);
    end
    if (frame_holding) begin
      return frame_report(ST_BUSY, PH_HOLD);
    end
    case (next_field)
      PH_ID: begin
        // bytes for other stations are dropped
        if (b == station_model) begin
          cap_slave = b;
          absorb_byte(b);
          next_field = PH_FUNC;
        end
      end
      PH_FUNC: begin
        cap_function = b;
        absorb_byte(b);
        next_field = PH_ADDR;
      end
      PH_ADDR: begin
        cap_address = {cap_address[7:0], b};
        absorb_byte(b);
        if (bytes_seen >= 4'd4) begin
          next_field = PH_COUNT;
        end
      end
      PH_COUNT: begin
        cap_quantity = {1'b0, cap_quantity[7:0], b};
        absorb_byte(b);
        // register count becomes a byte count once complete
        if (bytes_seen >= 4'd6) begin
          cap_quantity = {cap_quantity[15:0], 1'b0};
          next_field = PH_CRC;
        end
      end
      PH_CRC: begin
        cap_crc    = {cap_crc[7:0], b};
        bytes_seen = bytes_seen + 4'd1;
        if (bytes_seen >= 4'd8) begin
          // crc goes out low byte first
          wire_crc = {crc_acc[7:0], crc_acc[15:8]};
          if (cap_crc == wire_crc) begin
            frame_holding = 1'b1;
            next_field = PH_HOLD;
            return frame_report(ST_FRAME_OK, PH_HOLD);
          end
          r = frame_report(ST_CRC_ERR, PH_ID);
          restart_frame();
          return r;
        end
      end
      default: begin
        restart_frame();
      end
    endcase
    return frame_report(ST_PROGRESS, next_field);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus queue and helpers
  // ---------------------------------------------------------------------------
  in_item_t  pending_bytes[$];
  out_item_t expected_results[$];

  bit quiet = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;
  bit in_fire = 1'b0;

  int error_count = 0;
  int items_in = 0;
  int results_checked = 0;
  int frames_ok = 0;
  int crc_errors = 0;
  int busy_rejects = 0;
  int clears_seen = 0;
  int station_settings = 0;

  function automatic void push_byte(logic [7:0] b);
    in_item_t t;
    t.op      = OP_BYTE;
    t.rx_byte = b;
    pending_bytes.push_back(t);
  endfunction

  function automatic void push_clear();
    in_item_t t;
    t.op      = OP_CLEAR;
    t.rx_byte = 8'($urandom);
    pending_bytes.push_back(t);
  endfunction

  // extremes now and then, otherwise random
  function automatic logic [15:0] pick_word();
    int p;
    p = $urandom_range(99);
    if (p < 8) begin
      return 16'h0000;
    end else if (p < 16) begin
      return 16'hFFFF;
    end
    return 16'($urandom);
  endfunction

  // request frame with its crc; optionally one bit flipped, optionally cut short
  function automatic void push_frame(logic [7:0] id, logic [7:0] fn, logic [15:0] addr,
                                     logic [15:0] cnt, bit flip, int keep);
    logic [7:0]  fr[8];
    logic [15:0] c;
    fr[0] = id;
    fr[1] = fn;
    fr[2] = addr[15:8];
    fr[3] = addr[7:0];
    fr[4] = cnt[15:8];
    fr[5] = cnt[7:0];
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      c = crc16_modbus_step(c, fr[i]);
    end
    fr[6] = c[7:0];
    fr[7] = c[15:8];
    if (flip) begin
      fr[$urandom_range(7, 1)][$urandom_range(7, 0)] ^= 1'b1;
    end
    for (int i = 0; i < keep; i++) begin
      push_byte(fr[i]);
    end
  endfunction

  // random traffic, mostly well-formed requests; noise is counted only after a good frame
  task automatic fill_random(int n);
    int made;
    int pick;
    int k;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        push_frame(station_model, 8'($urandom), pick_word(), pick_word(), 1'b0, 8);
        k = $urandom_range(3);
        for (int i = 0; i < k; i++) begin
          push_byte(8'($urandom));
        end
        push_clear();
        made += 9 + k;
      end else if (pick < 78) begin
        push_frame(station_model, 8'($urandom), pick_word(), pick_word(), 1'b1, 8);
        made += 8;
      end else if (pick < 90) begin
        k = $urandom_range(6, 1);
        for (int i = 0; i < k; i++) begin
          push_byte(8'($urandom));
        end
        if ($urandom_range(1)) begin
          push_clear();
          made += 1;
        end
      end else begin
        k = $urandom_range(7, 1);
        push_frame(station_model, 8'($urandom), pick_word(), pick_word(), 1'b0, k);
        push_clear();
        made += k + 1;
      end
    end
  endtask

  // sender pauses until every transaction has its result back
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_station(logic [7:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    station_model = v;
    station_settings++;
  endtask

  task automatic note_error(string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
    if (got !== want) begin
      note_error($sformatf("%s expected 0x%0h actual 0x%0h", name, want, got));
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued transactions; unless quiet, idles at random when free
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_bytes.size() != 0 && (quiet || $urandom_range(99) >= 35)) begin
        in_data  <= pending_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random unless quiet, or a long hold when one is requested
  always @(negedge clk) begin : receiver
    int hold_left;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (holds_served < hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 35);
    end
  end

  // monitor: check results in order, predict each accepted transaction
  always @(posedge clk) begin : monitor
    out_item_t want;
    in_fire = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("result 0x%0h with nothing expected", out_data));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("status", 17'(want.status), 17'(out_data.status));
        check_field("phase", 17'(want.phase), 17'(out_data.phase));
        check_field("slave_id", 17'(want.slave_id), 17'(out_data.slave_id));
        check_field("function_code", 17'(want.function_code),
                    17'(out_data.function_code));
        check_field("start_address", 17'(want.start_address),
                    17'(out_data.start_address));
        check_field("quantity_bytes", want.quantity_bytes, out_data.quantity_bytes);
        check_field("received_crc", 17'(want.received_crc), 17'(out_data.received_crc));
        case (want.status)
          ST_FRAME_OK: frames_ok++;
          ST_CRC_ERR:  crc_errors++;
          ST_BUSY:     busy_rejects++;
          ST_CLEARED:  clears_seen++;
          default: ;
        endcase
      end
    end
    if (in_fire) begin
      expected_results.push_back(parse_request_byte(in_data));
      items_in++;
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin : watchdog
    int stuck;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck = 0;
    end else begin
      stuck = stuck + 1;
      if (stuck >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", stuck);
        $display("modbus_rtu_request_parser regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] stations[6];
    station_model = STATION_ID_RESET;
    restart_frame();
    stations = '{8'h00, 8'hFF, 8'h00, 8'h50, 8'hFF, 8'h00};
    stations[2] = 8'($urandom);
    stations[5] = 8'($urandom);

    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: id mismatch, max count frame, busy, clear mid-frame, crc error
    push_byte(8'h00);
    push_byte(8'hFF);
    push_frame(STATION_ID_RESET, 8'h03, 16'h0000, 16'hFFFF, 1'b0, 8);
    push_byte(8'hA5);
    push_clear();
    push_byte(STATION_ID_RESET);
    push_byte(8'h10);
    push_clear();
    push_frame(STATION_ID_RESET, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, 8);
    wait_idle();

    // random phases, one station id setting each
    for (int p = 0; p < 6; p++) begin
      write_station(stations[p]);
      if (p == 3) begin
        quiet = 1'b1;
      end
      fill_random(150);
      if (p == 1) begin
        hold_requests++;
      end
      wait_idle();
      quiet = 1'b0;
    end

    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      note_error($sformatf("%0d results never arrived", expected_results.size()));
    end
    $display("run covered %0d transactions, %0d results checked over %0d station ids",
             items_in, results_checked, station_settings + 1);
    $display("good frames %0d, crc errors %0d, busy rejects %0d, clears %0d, mismatches %0d",
             frames_ok, crc_errors, busy_rejects, clears_seen, error_count);
    if (error_count == 0) begin
      $display("modbus_rtu_request_parser regression: pass");
    end else begin
      $display("modbus_rtu_request_parser regression: fail");
    end
    $finish;
  end

endmodule
